[design/ccts_pkg.sv]
`default_nettype none

package ccts_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SampleWidth   = 32;
  localparam int unsigned SecondsWidth  = 45;
  localparam int unsigned SubWidth      = 10;
  localparam int unsigned TimelineWidth = 64;
  localparam int unsigned ClockWidth    = 10;

  // Shared divider geometry: 64-bit dividend, divisor up to the clock in hertz.
  localparam int unsigned DivWidth   = 64;
  localparam int unsigned DvsrWidth  = 30;
  localparam int unsigned StepWidth  = 7;
  localparam int unsigned ScaleWidth = 20;
  // What is left after the milliseconds is below the clock in kilohertz.
  localparam int unsigned MsRemWidth = 20;

  localparam logic [ScaleWidth-1:0] US_PER_S = 20'd1000000;
  localparam logic [ScaleWidth-1:0] MS_PER_S = 20'd1000;

  localparam logic [StepWidth-1:0] STEPS_WIDE  = 7'd64;
  localparam logic [StepWidth-1:0] STEPS_DELTA = 7'd32;
  localparam logic [StepWidth-1:0] STEPS_MS    = 7'd30;
  localparam logic [StepWidth-1:0] STEPS_US    = 7'd20;

  localparam logic [ClockWidth-1:0] CLOCK_MHZ_RESET = 10'd168;

  typedef enum logic [1:0] {
    OP_SECONDS,
    OP_MILLIS,
    OP_MICROS,
    OP_DELTA
  } op_e;

  typedef struct packed {
    logic [SampleWidth-1:0] counter_now;
    logic [SampleWidth-1:0] previous_count;
  } in_t;

  typedef struct packed {
    logic [SecondsWidth-1:0]  seconds;
    logic [SubWidth-1:0]      milliseconds;
    logic [SubWidth-1:0]      microseconds;
    logic [TimelineWidth-1:0] timeline_us;
    logic [SampleWidth-1:0]   delta_cycles;
    logic [SampleWidth-1:0]   delta_us;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic take;
    logic publish;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

[design/ccts_div.sv]
`default_nettype none

module ccts_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ccts_pkg::DivWidth-1:0]     dividend_i,
  input  wire logic [ccts_pkg::DvsrWidth-1:0]    divisor_i,
  input  wire logic [ccts_pkg::StepWidth-1:0]    steps_i,
  output logic                                   done_o,
  output logic [ccts_pkg::DivWidth-1:0]          quotient_o,
  output logic [ccts_pkg::DvsrWidth-1:0]         remainder_o
);
  import ccts_pkg::*;

  logic [DivWidth-1:0]  num_q, num_d;
  logic [DivWidth-1:0]  quot_q, quot_d;
  logic [DvsrWidth-1:0] rem_q, rem_d;
  logic [DvsrWidth-1:0] dvsr_q;
  logic [StepWidth-1:0] count_q;
  logic                 done_q;
  logic [DvsrWidth:0]   trial;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, num_q[DivWidth-1]};
    fits  = trial >= {1'b0, dvsr_q};
    num_d = {num_q[DivWidth-2:0], 1'b0};
    quot_d = {quot_q[DivWidth-2:0], fits};
    if (fits) begin
      rem_d = DvsrWidth'(trial - {1'b0, dvsr_q});
    end else begin
      rem_d = trial[DvsrWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        count_q <= steps_i;
      end else if (count_q != '0) begin
        count_q <= count_q - 1'b1;
        if (count_q == StepWidth'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      dvsr_q <= divisor_i;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (count_q != '0) begin
      num_q  <= num_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[design/ccts_datapath.sv]
`default_nettype none

module ccts_datapath #(
  parameter int unsigned CounterWidth = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ccts_pkg::ClockWidth-1:0]     cfg_data_i,
  input  wire ccts_pkg::in_t                       in_data_i,
  input  wire ccts_pkg::cmd_t                      cmd_i,
  output ccts_pkg::status_t                        status_o,
  output ccts_pkg::out_t                           out_data_o
);
  import ccts_pkg::*;

  localparam logic [SampleWidth-1:0] CntMask =
    SampleWidth'((64'd1 << CounterWidth) - 64'd1);

  logic [ClockWidth-1:0]    clock_mhz_q;
  logic [SampleWidth-1:0]   last_q;
  logic [SampleWidth-1:0]   wrap_q;
  logic [SampleWidth-1:0]   wrap_d;
  logic [DivWidth-1:0]      ext_q;
  logic [SampleWidth-1:0]   delta_q;
  logic [TimelineWidth-1:0] timeline_q;
  logic [SecondsWidth-1:0]  seconds_q;
  logic [DvsrWidth-1:0]     sub_q;
  logic [MsRemWidth-1:0]    ms_rem_q;
  logic [SubWidth-1:0]      ms_q;
  logic [SubWidth-1:0]      us_q;
  logic [SampleWidth-1:0]   delta_us_q;
  out_t                     out_q;

  logic [SampleWidth-1:0]   now_m;
  logic [SampleWidth-1:0]   mark_m;
  logic [ClockWidth-1:0]    mhz_eff;
  logic [DvsrWidth-1:0]     per_s;
  logic [DvsrWidth-1:0]     per_ms;
  logic [DivWidth-1:0]      div_dividend;
  logic [DvsrWidth-1:0]     div_divisor;
  logic [StepWidth-1:0]     div_steps;
  logic                     div_done;
  logic [DivWidth-1:0]      div_quot;
  logic [DvsrWidth-1:0]     div_rem;

  assign now_m   = in_data_i.counter_now & CntMask;
  assign mark_m  = in_data_i.previous_count & CntMask;
  assign wrap_d  = (now_m < last_q) ? wrap_q + 1'b1 : wrap_q;
  // A zero clock setting behaves as one megahertz.
  assign mhz_eff = (clock_mhz_q == '0) ? ClockWidth'(1) : clock_mhz_q;
  // The clock in hertz and in kilohertz; both fit the divisor width.
  assign per_s   = DvsrWidth'(mhz_eff) * DvsrWidth'(US_PER_S);
  assign per_ms  = DvsrWidth'(mhz_eff) * DvsrWidth'(MS_PER_S);

  // Narrow dividends are left-aligned so that only their own bits are stepped.
  always_comb begin
    unique case (cmd_i.op)
      OP_SECONDS: begin
        div_dividend = ext_q;
        div_divisor  = per_s;
        div_steps    = STEPS_WIDE;
      end
      OP_MILLIS: begin
        div_dividend = {sub_q, (DivWidth-DvsrWidth)'(0)};
        div_divisor  = per_ms;
        div_steps    = STEPS_MS;
      end
      OP_MICROS: begin
        div_dividend = {ms_rem_q, (DivWidth-MsRemWidth)'(0)};
        div_divisor  = DvsrWidth'(mhz_eff);
        div_steps    = STEPS_US;
      end
      OP_DELTA: begin
        div_dividend = {delta_q, (DivWidth-SampleWidth)'(0)};
        div_divisor  = DvsrWidth'(mhz_eff);
        div_steps    = STEPS_DELTA;
      end
      default: begin
        div_dividend = ext_q;
        div_divisor  = per_s;
        div_steps    = STEPS_WIDE;
      end
    endcase
  end

  ccts_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .steps_i     (div_steps),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_mhz_q <= CLOCK_MHZ_RESET;
      last_q      <= '0;
      wrap_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        clock_mhz_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        last_q <= now_m;
        wrap_q <= wrap_d;
      end
    end
  end

  // The microsecond total is built up as each part of the split arrives.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ext_q   <= (DivWidth'(wrap_d) << CounterWidth) | DivWidth'(now_m);
      delta_q <= SampleWidth'(now_m - mark_m) & CntMask;
    end
    if (cmd_i.take) begin
      unique case (cmd_i.op)
        OP_SECONDS: begin
          seconds_q  <= div_quot[SecondsWidth-1:0];
          sub_q      <= div_rem;
          timeline_q <= TimelineWidth'(div_quot[SecondsWidth-1:0]) *
                        TimelineWidth'(US_PER_S);
        end
        OP_MILLIS: begin
          ms_q       <= div_quot[SubWidth-1:0];
          ms_rem_q   <= div_rem[MsRemWidth-1:0];
          timeline_q <= timeline_q + TimelineWidth'(div_quot[SubWidth-1:0]) *
                        TimelineWidth'(MS_PER_S);
        end
        OP_MICROS: begin
          us_q       <= div_quot[SubWidth-1:0];
          timeline_q <= timeline_q + TimelineWidth'(div_quot[SubWidth-1:0]);
        end
        OP_DELTA: delta_us_q <= div_quot[SampleWidth-1:0];
        default: ;
      endcase
    end
    if (cmd_i.publish) begin
      out_q.seconds      <= seconds_q;
      out_q.milliseconds <= ms_q;
      out_q.microseconds <= us_q;
      out_q.timeline_us  <= timeline_q;
      out_q.delta_cycles <= delta_q;
      out_q.delta_us     <= delta_us_q;
    end
  end

  assign status_o.div_done = div_done;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

[design/ccts_ctrl.sv]
`default_nettype none

module ccts_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ccts_pkg::cmd_t          cmd_o,
  input  wire ccts_pkg::status_t  status_i
);
  import ccts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEC_START,
    S_SEC_WAIT,
    S_MS_START,
    S_MS_WAIT,
    S_US_START,
    S_US_WAIT,
    S_DELTA_START,
    S_DELTA_WAIT,
    S_PUBLISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  cmd_t   cmd;

  always_comb begin
    cmd = '{load: 1'b0, div_start: 1'b0, take: 1'b0, publish: 1'b0, op: OP_SECONDS};
    unique case (state_q)
      S_IDLE:        cmd.load = in_valid_i;
      S_SEC_START:   cmd.div_start = 1'b1;
      S_SEC_WAIT:    cmd.take = status_i.div_done;
      S_MS_START: begin
        cmd.op        = OP_MILLIS;
        cmd.div_start = 1'b1;
      end
      S_MS_WAIT: begin
        cmd.op   = OP_MILLIS;
        cmd.take = status_i.div_done;
      end
      S_US_START: begin
        cmd.op        = OP_MICROS;
        cmd.div_start = 1'b1;
      end
      S_US_WAIT: begin
        cmd.op   = OP_MICROS;
        cmd.take = status_i.div_done;
      end
      S_DELTA_START: begin
        cmd.op        = OP_DELTA;
        cmd.div_start = 1'b1;
      end
      S_DELTA_WAIT: begin
        cmd.op   = OP_DELTA;
        cmd.take = status_i.div_done;
      end
      S_PUBLISH:     cmd.publish = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:        if (in_valid_i) state_q <= S_SEC_START;
        S_SEC_START:   state_q <= S_SEC_WAIT;
        S_SEC_WAIT:    if (status_i.div_done) state_q <= S_MS_START;
        S_MS_START:    state_q <= S_MS_WAIT;
        S_MS_WAIT:     if (status_i.div_done) state_q <= S_US_START;
        S_US_START:    state_q <= S_US_WAIT;
        S_US_WAIT:     if (status_i.div_done) state_q <= S_DELTA_START;
        S_DELTA_START: state_q <= S_DELTA_WAIT;
        S_DELTA_WAIT:  if (status_i.div_done) state_q <= S_PUBLISH;
        S_PUBLISH:     if (cmd.publish) state_q <= S_IDLE;
        default:       state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

[design/cycle_counter_timestamp_splitter_top.sv]
`default_nettype none

// Cycle counter timestamp splitter. Each input beat carries a sample of a free-running
// cycle counter of CounterWidth bits and an earlier mark. A sample below the previous one
// counts a wrap, extending the count to wrap_count * 2^CounterWidth + sample. Using the
// clock frequency in MHz written through cfg_we_i/cfg_data_i (168 after reset, zero taken
// as one), the result beat gives the whole seconds of the extended count, the
// milliseconds and microseconds left over, the total in microseconds, the wrapped
// difference from the mark in cycles, and that difference in whole microseconds. The
// seconds come from dividing the extended count by the clock in hertz, the milliseconds
// from dividing the remainder by the clock in kilohertz, and the microseconds from
// dividing what is left by the clock in megahertz; the total is built up from the three
// parts. All four divisions share one radix-2 restoring divider stepping one quotient bit
// per cycle: 64 steps for the seconds, 30 for the milliseconds, 20 for the microseconds
// and 32 for the delta. The controller starts each division in a start state and takes
// its result in a wait state, then publishes once the output register is free or read.
// One beat is in work at a time; a finished result waits in the output register, and the
// next input beat is accepted while it does. Configuration is to be written only while
// the block is idle.
module cycle_counter_timestamp_splitter_top #(
  parameter int unsigned CounterWidth = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ccts_pkg::ClockWidth-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire ccts_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output ccts_pkg::out_t                       out_data_o
);
  import ccts_pkg::*;

  // The controller sequences the four divisions; the datapath holds every value.
  cmd_t    cmd;
  status_t status;

  ccts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ccts_datapath #(
    .CounterWidth (CounterWidth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[test/tb_cycle_counter_timestamp_splitter_top.sv]
// Testbench for the cycle counter timestamp splitter. Every accepted input beat is
// run through a predictor of the wrap extension and the time split. The prediction
// is queued, and each result beat is compared field by field with the oldest entry
// in that queue.
module tb_cycle_counter_timestamp_splitter_top;
  import ccts_pkg::*;

  localparam int unsigned CounterWidth  = 32;
  localparam logic [63:0] SampleMask    = (64'd1 << CounterWidth) - 64'd1;
  // The slowest correct gap between two accepted beats is the long hold-off
  // plus the work on a single item.
  localparam int unsigned WatchdogLimit = 6000;
  localparam int unsigned HoldCycles    = 700;
  localparam int unsigned PhaseBeats    = 150;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [ClockWidth-1:0] cfg_data    = CLOCK_MHZ_RESET;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_t                   in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_t                  out_data;

  // These copies of the block's state and its register are kept in step with the block.
  logic [ClockWidth-1:0] clock_setting = CLOCK_MHZ_RESET;
  logic [31:0]           last_sample   = '0;
  logic [31:0]           wrap_count    = '0;

  out_t        pending_stamps[$];
  logic [31:0] sample_walk  = '0;
  logic        valid_high   = 1'b0;
  logic        src_idle_en  = 1'b1;
  logic        rx_idle_en   = 1'b1;
  logic        hold_request = 1'b0;

  int unsigned beats_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned wraps_seen      = 0;
  int unsigned clock_writes    = 0;

  cycle_counter_timestamp_splitter_top #(
    .CounterWidth(CounterWidth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one beat. The wrap check and the sample update come
  // first, so the split already sees the new wrap count. A zero clock counts as 1 MHz.
  function automatic out_t predict_timestamp(input in_t beat);
    logic [63:0] now, mark, mhz, per_s, per_ms, ext, secs, rest, msec, usec, delta;
    out_t want;
    now    = 64'(beat.counter_now) & SampleMask;
    mark   = 64'(beat.previous_count) & SampleMask;
    mhz    = (clock_setting == '0) ? 64'd1 : 64'(clock_setting);
    per_s  = mhz * 64'(US_PER_S);
    per_ms = mhz * 64'(MS_PER_S);
    if (now < 64'(last_sample)) begin
      wrap_count = wrap_count + 32'd1;
      wraps_seen++;
    end
    last_sample = now[31:0];
    ext   = (64'(wrap_count) << CounterWidth) + now;
    secs  = ext / per_s;
    rest  = ext - secs * per_s;
    msec  = rest / per_ms;
    rest  = rest - msec * per_ms;
    usec  = rest / mhz;
    delta = (now - mark) & SampleMask;
    want.seconds      = secs[SecondsWidth-1:0];
    want.milliseconds = msec[SubWidth-1:0];
    want.microseconds = usec[SubWidth-1:0];
    want.timeline_us  = secs * 64'(US_PER_S) + msec * 64'(MS_PER_S) + usec;
    want.delta_cycles = delta[31:0];
    want.delta_us     = 32'(delta / mhz);
    return want;
  endfunction

  // A walking counter with random steps, jumps and step-backs, so that wraps come
  // often. The mark is mostly a little behind the sample, sometimes ahead of it.
  function automatic in_t make_random_stamp();
    in_t beat;
    case ($urandom_range(0, 9))
      0, 1: sample_walk = $urandom();
      2: sample_walk = sample_walk - $urandom_range(1, 1 << 16);
      3: sample_walk = sample_walk + $urandom();
      default: sample_walk = sample_walk + $urandom_range(0, 1 << 20);
    endcase
    beat.counter_now = sample_walk;
    case ($urandom_range(0, 7))
      0: beat.previous_count = $urandom();
      1: beat.previous_count = sample_walk + $urandom_range(1, 5000);
      2: beat.previous_count = sample_walk;
      default: beat.previous_count = sample_walk - $urandom_range(0, 1 << 22);
    endcase
    return beat;
  endfunction

  task automatic send_beat(input logic [31:0] now, input logic [31:0] mark);
    in_t beat;
    beat.counter_now    = now;
    beat.previous_count = mark;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      if (valid_high) begin
        in_valid   <= 1'b0;
        valid_high  = 1'b0;
      end
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= beat;
    valid_high  = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_stamps.push_back(predict_timestamp(beat));
    beats_sent++;
  endtask

  task automatic send_random(input int unsigned count);
    in_t beat;
    repeat (count) begin
      beat = make_random_stamp();
      send_beat(beat.counter_now, beat.previous_count);
    end
  endtask

  task automatic stop_sending();
    if (valid_high) begin
      in_valid   <= 1'b0;
      valid_high  = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  // The register may only change while the block is idle. Every beat gives a result,
  // so an empty queue means that nothing is in work.
  task automatic write_clock(input logic [ClockWidth-1:0] mhz);
    stop_sending();
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= mhz;
    @(posedge clk);
    cfg_we <= 1'b0;
    clock_setting = mhz;
    clock_writes++;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Result %0d, %s: expected %0h, got %0h", results_checked, field, want, got);
      end
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_stamps.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Result beat with nothing expected: %p", got);
      return;
    end
    want = pending_stamps.pop_front();
    results_checked++;
    compare_field("seconds", 64'(want.seconds), 64'(got.seconds));
    compare_field("milliseconds", 64'(want.milliseconds), 64'(got.milliseconds));
    compare_field("microseconds", 64'(want.microseconds), 64'(got.microseconds));
    compare_field("timeline_us", want.timeline_us, got.timeline_us);
    compare_field("delta_cycles", 64'(want.delta_cycles), 64'(got.delta_cycles));
    compare_field("delta_us", 64'(want.delta_us), 64'(got.delta_us));
  endtask

  // Result side: checks each accepted beat and drives the stall, either in short random
  // bursts or, on request, as one long hold-off counted here.
  initial begin : result_side
    int unsigned burst_left;
    int unsigned hold_left;
    logic        stall_next;
    burst_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) check_result(out_data);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left == 0 && burst_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 9);
      end
      stall_next = (hold_left != 0) || (burst_left != 0);
      if (hold_left != 0) begin
        hold_left--;
      end else if (burst_left != 0) begin
        burst_left--;
      end
      out_stall <= stall_next;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles", WatchdogLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Extremes of both fields at the reset clock: zeros, all ones, a wrap from the top of
  // the counter to zero, an equal sample that must not count as a wrap, and a mark ahead
  // of the sample so that the difference wraps.
  task automatic test_field_extremes();
    send_beat(32'h0000_0000, 32'h0000_0000);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_beat(32'h1234_5678, 32'h1234_5679);
    send_beat(32'h5555_5555, 32'h0000_0001);
  endtask

  // A zero clock, the lowest clock, 1000 MHz and the highest value of the 10-bit field.
  task automatic test_clock_extremes();
    write_clock('0);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(32'h0000_0001, 32'h0000_0002);
    write_clock(10'd1);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(32'h0000_0000, 32'h8000_0000);
    write_clock(10'd1000);
    send_beat(32'd999_999, 32'h0000_0000);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    write_clock(10'd1023);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(32'd1022, 32'h0000_0000);
    write_clock(CLOCK_MHZ_RESET);
  endtask

  task automatic test_random_traffic();
    logic [ClockWidth-1:0] settings[8];
    settings = '{CLOCK_MHZ_RESET, 10'd1, 10'd1000, 10'd1023, 10'd0,
                 ClockWidth'($urandom_range(2, 999)), ClockWidth'($urandom_range(1001, 1022)),
                 10'd500};
    foreach (settings[i]) begin
      write_clock(settings[i]);
      send_random(PhaseBeats);
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the result
  // register and the work slot both fill and the block stalls its input.
  task automatic test_output_hold_off();
    hold_request = 1'b1;
    send_random(12);
  endtask

  // The sender stops until every expected result has come, then carries on.
  task automatic test_drain_pause();
    send_random(20);
    stop_sending();
    wait_drained();
    send_random(20);
  endtask

  // Last part of the run: no idling on either side.
  task automatic test_streaming();
    write_clock(ClockWidth'($urandom_range(1, 1023)));
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    send_random(220);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_clock_extremes();
    test_random_traffic();
    test_output_hold_off();
    test_drain_pause();
    test_streaming();

    stop_sending();
    wait_drained();
    // Wait a while longer so that a stray result would still be caught.
    repeat (250) @(posedge clk);
    if (pending_stamps.size() != 0) begin
      mismatches += pending_stamps.size();
      $display("%0d expected results never arrived", pending_stamps.size());
    end

    $display("Covered %0d input beats and %0d checked results over %0d clock writes,",
             beats_sent, results_checked, clock_writes);
    $display("with %0d counter wraps, a long output hold-off and a full drain; %0d mismatches.",
             wraps_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
